// ===== rtl/rqsd_pkg.sv =====
package rqsd_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W  = 16;
  localparam int PAY_W  = 32;
  localparam int ENT_W  = KEY_W + PAY_W;
  localparam int POS_W  = 4;
  localparam int CMP_W  = (SLOT_W > POS_W) ? SLOT_W : POS_W;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef logic [SLOT_W-1:0] slot_t;

  // request actions
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_SRCH = 2'd2;
  localparam logic [1:0] ACT_DEL  = 2'd3;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BADPOS    = 2'd3;

  // read address select
  localparam logic [1:0] RA_HEAD = 2'd0;
  localparam logic [1:0] RA_SRCH = 2'd1;
  localparam logic [1:0] RA_DEL  = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic       enq_wr;
    logic       deq_adv;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_deq;
    logic       set_st;
    logic [1:0] st_code;
    logic       p_init;
    logic       p_inc;
    logic       set_found;
    logic       t_init;
    logic       del_wr;
    logic       tail_dec;
    logic       cap_head;
    logic       clr_head;
    logic       load_out;
  } rqsd_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       t_at_tail;
    logic       key_match;
    logic       srch_last;
  } rqsd_sts_t;

  function automatic slot_t next_slot(slot_t s);
    return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic slot_t prev_slot(slot_t s);
    return (s == '0) ? SLOT_W'(SLOTS - 1) : s - 1'b1;
  endfunction

  // base + off modulo SLOTS, valid when off < SLOTS
  function automatic slot_t add_slot(slot_t base, logic [CMP_W-1:0] off);
    logic [CMP_W:0] sum;
    sum = {1'b0, CMP_W'(base)} + {1'b0, off};
    if (sum >= (CMP_W + 1)'(SLOTS)) begin
      sum = sum - (CMP_W + 1)'(SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic slot_t live_count(slot_t head, slot_t tail);
    logic [SLOT_W:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + (SLOT_W + 1)'(SLOTS) - {1'b0, head};
    end
    return diff[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/rqsd_dp.sv =====
module rqsd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rqsd_pkg::rqsd_cmd_t          cmd,
  output rqsd_pkg::rqsd_sts_t          sts,
  input  logic [1:0]                   in_action,
  input  logic [rqsd_pkg::KEY_W-1:0]   in_key,
  input  logic [rqsd_pkg::PAY_W-1:0]   in_payload,
  input  logic [rqsd_pkg::POS_W-1:0]   in_position,
  output logic [1:0]                   out_status,
  output logic [rqsd_pkg::KEY_W-1:0]   out_key,
  output logic [rqsd_pkg::PAY_W-1:0]   out_payload,
  output logic [rqsd_pkg::POS_W-1:0]   out_found_position,
  output logic [rqsd_pkg::POS_W-1:0]   out_count,
  output logic                         out_head_valid,
  output logic [rqsd_pkg::KEY_W-1:0]   out_head_key,
  output logic [rqsd_pkg::PAY_W-1:0]   out_head_payload
);
  import rqsd_pkg::*;

  logic [ENT_W-1:0] mem [SLOTS];
  logic [ENT_W-1:0] rd_data_r;

  slot_t head_r, head_nxt;
  slot_t tail_r, tail_nxt;
  slot_t t_r;
  logic [POS_W-1:0] p_r;

  logic [1:0]       action_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [POS_W-1:0] pos_r;

  logic [1:0]       status_r;
  logic [KEY_W-1:0] okey_r;
  logic [PAY_W-1:0] opay_r;
  logic [POS_W-1:0] found_r;
  logic [KEY_W-1:0] hkey_r;
  logic [PAY_W-1:0] hpay_r;

  logic [1:0]       out_status_r;
  logic [KEY_W-1:0] out_key_r;
  logic [PAY_W-1:0] out_payload_r;
  logic [POS_W-1:0] out_found_r;
  logic [POS_W-1:0] out_count_r;
  logic             out_hvalid_r;
  logic [KEY_W-1:0] out_hkey_r;
  logic [PAY_W-1:0] out_hpay_r;

  slot_t            n_cur;
  logic [CMP_W-1:0] n_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] p_x;
  slot_t            rd_addr;
  slot_t            wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             wr_en;

  assign n_cur = live_count(head_r, tail_r);
  assign n_x   = CMP_W'(n_cur);
  assign pos_x = CMP_W'(pos_r);
  assign p_x   = CMP_W'(p_r);

  assign sts.action    = action_r;
  assign sts.full      = (next_slot(tail_r) == head_r);
  assign sts.empty     = (head_r == tail_r);
  assign sts.pos_bad   = (pos_r == '0) || (pos_x > n_x);
  assign sts.t_at_tail = (t_r == tail_r);
  assign sts.key_match = (rd_data_r[ENT_W-1:PAY_W] == key_r);
  assign sts.srch_last = (p_r == POS_MAX) || (p_x == n_x);

  always_comb begin
    unique case (cmd.rd_sel)
      RA_HEAD: rd_addr = next_slot(head_r);
      RA_SRCH: rd_addr = add_slot(head_r, p_x);
      RA_DEL:  rd_addr = next_slot(t_r);
      default: rd_addr = next_slot(head_r);
    endcase
  end

  assign wr_en   = cmd.enq_wr | cmd.del_wr;
  assign wr_addr = cmd.enq_wr ? next_slot(tail_r) : t_r;
  assign wr_data = cmd.enq_wr ? {key_r, pay_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cmd.deq_adv) begin
      head_nxt = next_slot(head_r);
    end
    if (cmd.enq_wr) begin
      tail_nxt = next_slot(tail_r);
    end else if (cmd.tail_dec) begin
      tail_nxt = prev_slot(tail_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r <= in_action;
      key_r    <= in_key;
      pay_r    <= in_payload;
      pos_r    <= in_position;
      status_r <= ST_OK;
      okey_r   <= '0;
      opay_r   <= '0;
      found_r  <= '0;
    end
    if (cmd.set_st) begin
      status_r <= cmd.st_code;
    end
    if (cmd.cap_deq) begin
      okey_r <= rd_data_r[ENT_W-1:PAY_W];
      opay_r <= rd_data_r[PAY_W-1:0];
    end
    if (cmd.p_init) begin
      p_r <= POS_W'(1);
    end else if (cmd.p_inc) begin
      p_r <= p_r + 1'b1;
    end
    if (cmd.set_found) begin
      found_r <= p_r;
    end
    if (cmd.t_init) begin
      t_r <= add_slot(head_r, pos_x);
    end else if (cmd.del_wr) begin
      t_r <= next_slot(t_r);
    end
    if (cmd.cap_head) begin
      hkey_r <= rd_data_r[ENT_W-1:PAY_W];
      hpay_r <= rd_data_r[PAY_W-1:0];
    end else if (cmd.clr_head) begin
      hkey_r <= '0;
      hpay_r <= '0;
    end
  end

  // output register, loaded once the item is finished
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= status_r;
      out_key_r     <= okey_r;
      out_payload_r <= opay_r;
      out_found_r   <= found_r;
      out_count_r   <= (n_x > CMP_W'(POS_MAX)) ? POS_MAX : n_x[POS_W-1:0];
      out_hvalid_r  <= (n_cur != '0);
      out_hkey_r    <= hkey_r;
      out_hpay_r    <= hpay_r;
    end
  end

  assign out_status         = out_status_r;
  assign out_key            = out_key_r;
  assign out_payload        = out_payload_r;
  assign out_found_position = out_found_r;
  assign out_count          = out_count_r;
  assign out_head_valid     = out_hvalid_r;
  assign out_head_key       = out_hkey_r;
  assign out_head_payload   = out_hpay_r;

  a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_wr |-> (next_slot(tail_r) != head_r))
    else $error("enqueue write into a full ring");

  a_tail_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tail_dec |-> (head_r != tail_r))
    else $error("tail retreat on an empty ring");

endmodule

// ===== rtl/rqsd_ctrl.sv =====
module rqsd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rqsd_pkg::rqsd_sts_t  sts,
  output rqsd_pkg::rqsd_cmd_t  cmd
);
  import rqsd_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_DEQ_CAP  = 4'd2;
  localparam logic [3:0] S_SRCH_RD  = 4'd3;
  localparam logic [3:0] S_SRCH_CMP = 4'd4;
  localparam logic [3:0] S_DEL_RD   = 4'd5;
  localparam logic [3:0] S_DEL_WR   = 4'd6;
  localparam logic [3:0] S_HEAD_RD  = 4'd7;
  localparam logic [3:0] S_HEAD_CAP = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel  = RA_HEAD;
    cmd.st_code = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_HEAD_RD;
        unique case (sts.action)
          ACT_ENQ: begin
            if (sts.full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_OVERFLOW;
            end else begin
              cmd.enq_wr = 1'b1;
            end
          end
          ACT_DEQ: begin
            if (sts.empty) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_UNDERFLOW;
            end else begin
              // read the slot the head moves onto
              cmd.deq_adv = 1'b1;
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RA_HEAD;
              state_nxt   = S_DEQ_CAP;
            end
          end
          ACT_SRCH: begin
            cmd.p_init = 1'b1;
            if (!sts.empty) begin
              state_nxt = S_SRCH_RD;
            end
          end
          ACT_DEL: begin
            if (sts.pos_bad) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_BADPOS;
            end else begin
              cmd.t_init = 1'b1;
              state_nxt  = S_DEL_RD;
            end
          end
          default: state_nxt = S_HEAD_RD;
        endcase
      end
      S_DEQ_CAP: begin
        cmd.cap_deq = 1'b1;
        state_nxt   = S_HEAD_RD;
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_SRCH;
        state_nxt  = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts.key_match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_HEAD_RD;
        end else if (sts.srch_last) begin
          state_nxt = S_HEAD_RD;
        end else begin
          cmd.p_inc = 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_DEL_RD: begin
        if (sts.t_at_tail) begin
          cmd.tail_dec = 1'b1;
          state_nxt    = S_HEAD_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_DEL;
          state_nxt  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.del_wr = 1'b1;
        state_nxt  = S_DEL_RD;
      end
      S_HEAD_RD: begin
        if (sts.empty) begin
          cmd.clr_head = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_HEAD;
          state_nxt  = S_HEAD_CAP;
        end
      end
      S_HEAD_CAP: begin
        cmd.cap_head = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request did not start execution");

  a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_RD) |-> !sts.empty)
    else $error("delete walk on an empty ring");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

endmodule

// ===== rtl/ring_queue_with_search_delete.sv =====
// Ring-buffer queue of key/payload entries with search and positional delete.
// Input channel (in_valid/in_ready) carries one request: in_action selects
// enqueue, dequeue, search by key or delete at a 1-based position from head.
// Result channel (out_valid/out_ready) returns exactly one result per request:
// status, dequeued entry, found position, count and the head entry afterward.
// One request is in flight at a time; in_ready is high only while idle.
// The sequencer steps through the entry memory, whose reads are registered:
// a search reads and compares one entry at a time (up to 15 entries), and
// a delete at position p shifts each later entry one slot toward the head,
// then retreats the tail. Every request ends by reading the head entry,
// a read skipped when the queue is empty afterward.
// A further request is accepted the cycle after the result is loaded, even
// while that result still waits in the output register. If the receiver
// stalls with a result pending, the next request completes internally and
// waits until the pending result is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; the entry memory itself is not cleared.
module ring_queue_with_search_delete (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [rqsd_pkg::KEY_W-1:0]   in_key,
  input  logic [rqsd_pkg::PAY_W-1:0]   in_payload,
  input  logic [rqsd_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [rqsd_pkg::KEY_W-1:0]   out_key,
  output logic [rqsd_pkg::PAY_W-1:0]   out_payload,
  output logic [rqsd_pkg::POS_W-1:0]   out_found_position,
  output logic [rqsd_pkg::POS_W-1:0]   out_count,
  output logic                         out_head_valid,
  output logic [rqsd_pkg::KEY_W-1:0]   out_head_key,
  output logic [rqsd_pkg::PAY_W-1:0]   out_head_payload
);
  import rqsd_pkg::*;

  rqsd_cmd_t cmd;
  rqsd_sts_t sts;

  rqsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rqsd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .in_position        (in_position),
    .out_status         (out_status),
    .out_key            (out_key),
    .out_payload        (out_payload),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_head_valid     (out_head_valid),
    .out_head_key       (out_head_key),
    .out_head_payload   (out_head_payload)
  );

endmodule
